// ===== rtl/elt_pkg.sv =====
// ----------------------------------------------------------------------------
// elt_pkg: shared types and constants of the expression line tokenizer
// Holds the payload structs of both channels, the character class record
// that travels from the front to the back, and the token kind codes.
// ----------------------------------------------------------------------------
package elt_pkg;

    // Width of a code point on the ports.
    localparam int CHAR_W = 21;

    // Largest number of results one item can cause.
    localparam int MAX_RESULTS = 3;
    localparam int RES_CW      = $clog2(MAX_RESULTS + 1);

    // Token kind codes.
    localparam logic [2:0] KIND_WORD   = 3'd0;
    localparam logic [2:0] KIND_NUMBER = 3'd1;
    localparam logic [2:0] KIND_STRING = 3'd2;
    localparam logic [2:0] KIND_CMP    = 3'd3;
    localparam logic [2:0] KIND_NOT    = 3'd4;
    localparam logic [2:0] KIND_AND    = 3'd5;
    localparam logic [2:0] KIND_OR     = 3'd6;

    // Code points with a meaning of their own.
    localparam logic [CHAR_W-1:0] CH_NUL    = 21'h00000;
    localparam logic [CHAR_W-1:0] CH_TAB    = 21'h00009;
    localparam logic [CHAR_W-1:0] CH_LF     = 21'h0000A;
    localparam logic [CHAR_W-1:0] CH_CR     = 21'h0000D;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 21'h00020;
    localparam logic [CHAR_W-1:0] CH_BANG   = 21'h00021;
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 21'h00022;
    localparam logic [CHAR_W-1:0] CH_HASH   = 21'h00023;
    localparam logic [CHAR_W-1:0] CH_PCT    = 21'h00025;
    localparam logic [CHAR_W-1:0] CH_AMP    = 21'h00026;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 21'h00028;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 21'h00029;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 21'h0002D;
    localparam logic [CHAR_W-1:0] CH_DOT    = 21'h0002E;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 21'h00030;
    localparam logic [CHAR_W-1:0] CH_NINE   = 21'h00039;
    localparam logic [CHAR_W-1:0] CH_LT     = 21'h0003C;
    localparam logic [CHAR_W-1:0] CH_EQ     = 21'h0003D;
    localparam logic [CHAR_W-1:0] CH_GT     = 21'h0003E;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 21'h00041;
    localparam logic [CHAR_W-1:0] CH_UP_Z   = 21'h0005A;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 21'h0005C;
    localparam logic [CHAR_W-1:0] CH_UNDER  = 21'h0005F;
    localparam logic [CHAR_W-1:0] CH_LO_A   = 21'h00061;
    localparam logic [CHAR_W-1:0] CH_LO_Z   = 21'h0007A;
    localparam logic [CHAR_W-1:0] CH_BAR    = 21'h0007C;
    localparam logic [CHAR_W-1:0] CH_STAR   = 21'h02605;

    // One input item.
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              end_of_line;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic [2:0]        token_kind;
        logic              token_first;
        logic              token_last;
        logic              token_empty;
        logic              run_last;
    } out_item_t;

    // Character classes found by the front.
    typedef struct packed {
        logic ws;
        logic digit;
        logic alpha;
        logic word;
        logic quote;
        logic bslash;
        logic star;
        logic minus;
        logic dot;
        logic eq;
        logic op1;
        logic paren;
        logic skip_mark;
    } char_class_t;

    // Control part of one queued item.
    typedef struct packed {
        logic        eol;
        char_class_t cls;
    } char_info_t;

    // The results of one item, written to the result queue together.
    typedef struct packed {
        out_item_t [MAX_RESULTS-1:0] item;
        logic [RES_CW-1:0]           count;
    } res_group_t;

endpackage

// ===== rtl/elt_front.sv =====
// ----------------------------------------------------------------------------
// elt_front: input side of the tokenizer
// Takes code points, reduces them to CODE_BITS, classifies them and holds
// them in a two-entry queue until the back takes them.
// ----------------------------------------------------------------------------
module elt_front
    import elt_pkg::*;
#(
    parameter int CODE_BITS = 21
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  in_item_t             symbol,
    output logic                 head_valid,
    output logic [CODE_BITS-1:0] head_code,
    output char_info_t           head_info,
    input  logic                 head_pop
);

    function automatic char_class_t classify(logic [CHAR_W-1:0] x);
        char_class_t k;
        k.ws        = (x == CH_SPACE) || (x == CH_TAB) || (x == CH_CR) || (x == CH_LF);
        k.digit     = (x >= CH_ZERO) && (x <= CH_NINE);
        k.alpha     = ((x >= CH_LO_A) && (x <= CH_LO_Z)) || ((x >= CH_UP_A) && (x <= CH_UP_Z));
        k.word      = k.alpha || k.digit || (x == CH_UNDER);
        k.quote     = (x == CH_QUOTE);
        k.bslash    = (x == CH_BSLASH);
        k.star      = (x == CH_STAR);
        k.minus     = (x == CH_MINUS);
        k.dot       = (x == CH_DOT);
        k.eq        = (x == CH_EQ);
        k.op1       = (x == CH_BANG) || (x == CH_GT) || (x == CH_LT) || (x == CH_EQ) ||
                      (x == CH_AMP) || (x == CH_BAR);
        k.paren     = (x == CH_LPAREN) || (x == CH_RPAREN);
        k.skip_mark = (x == CH_HASH) || (x == CH_PCT);
        return k;
    endfunction

    logic [CODE_BITS-1:0] code_mem [2];
    char_info_t           info_mem [2];
    logic                 wptr_reg;
    logic                 rptr_reg;
    logic [1:0]           count_reg;
    logic                 push_fire;
    logic                 pop_fire;
    logic [CODE_BITS-1:0] in_code;

    // Only the low CODE_BITS bits of a code point take part.
    assign in_code    = symbol.char_code[CODE_BITS-1:0];
    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign push_fire  = push && !full;
    assign pop_fire   = head_pop && head_valid;
    assign head_code  = code_mem[rptr_reg];
    assign head_info  = info_mem[rptr_reg];

    // Queue storage, written on each input transfer.
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            code_mem[wptr_reg]     <= in_code;
            info_mem[wptr_reg].eol <= symbol.end_of_line;
            info_mem[wptr_reg].cls <= classify(CHAR_W'(in_code));
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push_fire)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop_fire)
            begin
                rptr_reg <= !rptr_reg;
            end
            count_reg <= count_reg + {1'b0, push_fire} - {1'b0, pop_fire};
        end
    end

endmodule

// ===== rtl/elt_back.sv =====
// ----------------------------------------------------------------------------
// elt_back: token scanner of the tokenizer
// While room is high, takes one classified code point a cycle from the front
// queue, advances the scan state and writes up to three results it causes at once.
// ----------------------------------------------------------------------------
module elt_back
    import elt_pkg::*;
#(
    parameter int CODE_BITS = 21
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  logic [CODE_BITS-1:0] head_code,
    input  char_info_t           head_info,
    output logic                 head_pop,
    input  logic                 room,
    output res_group_t           results
);

    typedef enum logic [3:0] {
        M_IDLE,
        M_WORD,
        M_NUM,
        M_NUMDOT,
        M_MINUS,
        M_STR,
        M_STRBS,
        M_STAR,
        M_OP1,
        M_OTHER
    } mode_t;

    mode_t                mode_reg,          mode_next;
    logic [CODE_BITS-1:0] held_reg,          held_next;
    logic                 held_valid_reg,    held_valid_next;
    logic                 dot_seen_reg,      dot_seen_next;
    logic                 token_started_reg, token_started_next;
    logic                 line_skipped_reg,  line_skipped_next;
    logic                 at_line_start_reg, at_line_start_next;
    res_group_t           group;
    logic                 fire;

    function automatic out_item_t mk(logic [CHAR_W-1:0] ch, logic [2:0] kind,
                                     logic f, logic l, logic e);
        out_item_t r;
        r.out_char    = ch;
        r.token_kind  = kind;
        r.token_first = f;
        r.token_last  = l;
        r.token_empty = e;
        r.run_last    = 1'b0;
        return r;
    endfunction

    function automatic res_group_t add(res_group_t g, out_item_t r);
        res_group_t o;
        o = g;
        if (o.count != RES_CW'(MAX_RESULTS))
        begin
            o.item[o.count] = r;
            o.count         = o.count + RES_CW'(1);
        end
        return o;
    endfunction

    assign fire     = head_valid && room;
    assign head_pop = fire;

    // Scan step for the item at the head of the queue.
    always_comb
    begin
        mode_t                m;
        logic [CODE_BITS-1:0] h;
        logic                 hv;
        logic                 ds;
        logic                 ts;
        logic                 ls;
        logic                 als;
        logic                 fresh;
        logic                 to_other;
        logic                 to_str;
        logic [CODE_BITS-1:0] c;
        logic [CHAR_W-1:0]    cx;
        logic [CHAR_W-1:0]    hx;
        logic [2:0]           k;
        char_class_t          cl;
        res_group_t           g;

        m        = mode_reg;
        h        = held_reg;
        hv       = held_valid_reg;
        ds       = dot_seen_reg;
        ts       = token_started_reg;
        ls       = line_skipped_reg;
        als      = at_line_start_reg;
        fresh    = 1'b0;
        to_other = 1'b0;
        to_str   = 1'b0;
        c        = head_code;
        cx       = CHAR_W'(head_code);
        hx       = CHAR_W'(held_reg);
        cl       = head_info.cls;
        k        = KIND_OR;
        g        = '0;

        // A comment mark at the start of a line drops the whole line.
        if (als)
        begin
            als = 1'b0;
            if (cl.skip_mark)
            begin
                ls = 1'b1;
            end
        end

        // First reaction of the current mode.
        if (!ls)
        begin
            unique case (m)
                M_IDLE:
                begin
                    fresh = 1'b1;
                end
                M_WORD:
                begin
                    if (cl.word)
                    begin
                        g  = add(g, mk(CHAR_W'(h), KIND_WORD, !ts, 1'b0, 1'b0));
                        ts = 1'b1;
                        h  = c;
                    end
                    else
                    begin
                        g     = add(g, mk(CHAR_W'(h), KIND_WORD, !ts, 1'b1, 1'b0));
                        fresh = 1'b1;
                    end
                end
                M_NUM:
                begin
                    if (cl.digit)
                    begin
                        g  = add(g, mk(CHAR_W'(h), KIND_NUMBER, !ts, 1'b0, 1'b0));
                        ts = 1'b1;
                        h  = c;
                    end
                    else if (cl.dot && !ds)
                    begin
                        hv = 1'b1;
                        m  = M_NUMDOT;
                    end
                    else
                    begin
                        g     = add(g, mk(CHAR_W'(h), KIND_NUMBER, !ts, 1'b1, 1'b0));
                        fresh = 1'b1;
                    end
                end
                M_NUMDOT:
                begin
                    if (cl.digit)
                    begin
                        g  = add(g, mk(CHAR_W'(h), KIND_NUMBER, !ts, 1'b0, 1'b0));
                        g  = add(g, mk(CH_DOT, KIND_NUMBER, 1'b0, 1'b0, 1'b0));
                        ts = 1'b1;
                        h  = c;
                        hv = 1'b1;
                        ds = 1'b1;
                        m  = M_NUM;
                    end
                    else
                    begin
                        // The dot starts a run of its own.
                        g        = add(g, mk(CHAR_W'(h), KIND_NUMBER, !ts, 1'b1, 1'b0));
                        m        = M_OTHER;
                        h        = CODE_BITS'(CH_DOT);
                        hv       = 1'b1;
                        ds       = 1'b0;
                        ts       = 1'b0;
                        to_other = 1'b1;
                    end
                end
                M_MINUS:
                begin
                    if (cl.digit)
                    begin
                        g  = add(g, mk(CHAR_W'(h), KIND_NUMBER, !ts, 1'b0, 1'b0));
                        ts = 1'b1;
                        h  = c;
                        ds = 1'b0;
                        m  = M_NUM;
                    end
                    else
                    begin
                        m        = M_OTHER;
                        h        = CODE_BITS'(CH_MINUS);
                        hv       = 1'b1;
                        ds       = 1'b0;
                        ts       = 1'b0;
                        to_other = 1'b1;
                    end
                end
                M_STR:
                begin
                    to_str = 1'b1;
                end
                M_STRBS:
                begin
                    m  = M_STR;
                    hv = 1'b1;
                    if (cl.quote)
                    begin
                        h = c;
                    end
                    else
                    begin
                        // The backslash is kept as text.
                        h      = CODE_BITS'(CH_BSLASH);
                        to_str = 1'b1;
                    end
                end
                M_STAR:
                begin
                    if (cl.star)
                    begin
                        g  = add(g, mk(CHAR_W'(h), KIND_STRING, !ts, 1'b0, 1'b0));
                        ts = 1'b1;
                        h  = c;
                    end
                    else
                    begin
                        g     = add(g, mk(CHAR_W'(h), KIND_STRING, !ts, 1'b1, 1'b0));
                        fresh = 1'b1;
                    end
                end
                M_OP1:
                begin
                    if ((hx == CH_BANG) || (hx == CH_GT) || (hx == CH_LT))
                    begin
                        if (cl.eq)
                        begin
                            g = add(g, mk(hx, KIND_CMP, 1'b1, 1'b0, 1'b0));
                            g = add(g, mk(cx, KIND_CMP, 1'b0, 1'b1, 1'b0));
                            m  = M_IDLE;
                            h  = '0;
                            hv = 1'b0;
                            ds = 1'b0;
                            ts = 1'b0;
                        end
                        else
                        begin
                            g = add(g, mk(hx, (hx == CH_BANG) ? KIND_NOT : KIND_CMP,
                                          1'b1, 1'b1, 1'b0));
                            fresh = 1'b1;
                        end
                    end
                    else if (c == held_reg)
                    begin
                        if (hx == CH_EQ)
                        begin
                            k = KIND_CMP;
                        end
                        else if (hx == CH_AMP)
                        begin
                            k = KIND_AND;
                        end
                        else
                        begin
                            k = KIND_OR;
                        end
                        g  = add(g, mk(hx, k, 1'b1, 1'b0, 1'b0));
                        g  = add(g, mk(cx, k, 1'b0, 1'b1, 1'b0));
                        m  = M_IDLE;
                        h  = '0;
                        hv = 1'b0;
                        ds = 1'b0;
                        ts = 1'b0;
                    end
                    else
                    begin
                        // A lone '=', '&' or '|' starts an other-run.
                        m        = M_OTHER;
                        h        = held_reg;
                        hv       = 1'b1;
                        ds       = 1'b0;
                        ts       = 1'b0;
                        to_other = 1'b1;
                    end
                end
                M_OTHER:
                begin
                    to_other = 1'b1;
                end
                default:
                begin
                    fresh = 1'b1;
                end
            endcase
        end

        // Start of a new token after the previous one ended.
        if (fresh)
        begin
            if (fresh && !cl.ws)
            begin
                m  = M_IDLE;
                h  = c;
                hv = 1'b1;
                ds = 1'b0;
                ts = 1'b0;
                if (cl.alpha)
                begin
                    m = M_WORD;
                end
                else if (cl.digit)
                begin
                    m = M_NUM;
                end
                else if (cl.minus)
                begin
                    m = M_MINUS;
                end
                else if (cl.quote)
                begin
                    m  = M_STR;
                    h  = '0;
                    hv = 1'b0;
                end
                else if (cl.star)
                begin
                    m = M_STAR;
                end
                else if (cl.op1)
                begin
                    m = M_OP1;
                end
                else if (cl.paren)
                begin
                    g  = add(g, mk(cx, KIND_WORD, 1'b1, 1'b1, 1'b0));
                    h  = '0;
                    hv = 1'b0;
                end
                else
                begin
                    m = M_OTHER;
                end
            end
            else
            begin
                // Whitespace between tokens leaves the scanner idle.
                m  = M_IDLE;
                h  = '0;
                hv = 1'b0;
                ds = 1'b0;
                ts = 1'b0;
            end
        end

        // Other-run: it goes up to the next whitespace.
        if (to_other)
        begin
            if (cl.ws)
            begin
                g  = add(g, mk(CHAR_W'(h), KIND_WORD, !ts, 1'b1, 1'b0));
                m  = M_IDLE;
                h  = '0;
                hv = 1'b0;
                ds = 1'b0;
                ts = 1'b0;
            end
            else
            begin
                g  = add(g, mk(CHAR_W'(h), KIND_WORD, !ts, 1'b0, 1'b0));
                ts = 1'b1;
                h  = c;
            end
        end

        // Quoted string body.
        if (to_str)
        begin
            if (cl.quote)
            begin
                if (hv)
                begin
                    g = add(g, mk(CHAR_W'(h), KIND_STRING, !ts, 1'b1, 1'b0));
                end
                else
                begin
                    g = add(g, mk(CH_NUL, KIND_STRING, 1'b1, 1'b1, 1'b1));
                end
                m  = M_IDLE;
                h  = '0;
                hv = 1'b0;
                ds = 1'b0;
                ts = 1'b0;
            end
            else if (cl.bslash)
            begin
                if (hv)
                begin
                    g  = add(g, mk(CHAR_W'(h), KIND_STRING, !ts, 1'b0, 1'b0));
                    ts = 1'b1;
                end
                hv = 1'b0;
                m  = M_STRBS;
            end
            else
            begin
                if (hv)
                begin
                    g  = add(g, mk(CHAR_W'(h), KIND_STRING, !ts, 1'b0, 1'b0));
                    ts = 1'b1;
                end
                h  = c;
                hv = 1'b1;
            end
        end

        // End of line releases everything still held.
        if (head_info.eol)
        begin
            unique case (m)
                M_IDLE:
                begin
                    g = g;
                end
                M_WORD, M_OTHER:
                begin
                    g = add(g, mk(CHAR_W'(h), KIND_WORD, !ts, 1'b1, 1'b0));
                end
                M_NUM:
                begin
                    g = add(g, mk(CHAR_W'(h), KIND_NUMBER, !ts, 1'b1, 1'b0));
                end
                M_NUMDOT:
                begin
                    g = add(g, mk(CHAR_W'(h), KIND_NUMBER, !ts, 1'b1, 1'b0));
                    g = add(g, mk(CH_DOT, KIND_WORD, 1'b1, 1'b1, 1'b0));
                end
                M_MINUS:
                begin
                    g = add(g, mk(CH_MINUS, KIND_WORD, 1'b1, 1'b1, 1'b0));
                end
                M_STR:
                begin
                    if (hv)
                    begin
                        g = add(g, mk(CHAR_W'(h), KIND_STRING, !ts, 1'b1, 1'b0));
                    end
                    else
                    begin
                        g = add(g, mk(CH_NUL, KIND_STRING, 1'b1, 1'b1, 1'b1));
                    end
                end
                M_STRBS:
                begin
                    g = add(g, mk(CH_BSLASH, KIND_STRING, !ts, 1'b1, 1'b0));
                end
                M_STAR:
                begin
                    g = add(g, mk(CHAR_W'(h), KIND_STRING, !ts, 1'b1, 1'b0));
                end
                M_OP1:
                begin
                    hx = CHAR_W'(h);
                    if (hx == CH_BANG)
                    begin
                        k = KIND_NOT;
                    end
                    else if ((hx == CH_GT) || (hx == CH_LT))
                    begin
                        k = KIND_CMP;
                    end
                    else
                    begin
                        k = KIND_WORD;
                    end
                    g = add(g, mk(hx, k, 1'b1, 1'b1, 1'b0));
                end
                default:
                begin
                    g = g;
                end
            endcase
            m   = M_IDLE;
            h   = '0;
            hv  = 1'b0;
            ds  = 1'b0;
            ts  = 1'b0;
            als = 1'b1;
            ls  = 1'b0;
        end

        // Mark the last result of this item.
        if (g.count != '0)
        begin
            g.item[g.count - RES_CW'(1)].run_last = 1'b1;
        end

        mode_next          = m;
        held_next          = h;
        held_valid_next    = hv;
        dot_seen_next      = ds;
        token_started_next = ts;
        line_skipped_next  = ls;
        at_line_start_next = als;
        group              = g;
    end

    // Results go to the result queue only on a transfer from the front.
    always_comb
    begin
        results = group;
        if (!fire)
        begin
            results.count = '0;
        end
    end

    // Scan state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= M_IDLE;
            held_reg          <= '0;
            held_valid_reg    <= 1'b0;
            dot_seen_reg      <= 1'b0;
            token_started_reg <= 1'b0;
            line_skipped_reg  <= 1'b0;
            at_line_start_reg <= 1'b1;
        end
        else if (fire)
        begin
            mode_reg          <= mode_next;
            held_reg          <= held_next;
            held_valid_reg    <= held_valid_next;
            dot_seen_reg      <= dot_seen_next;
            token_started_reg <= token_started_next;
            line_skipped_reg  <= line_skipped_next;
            at_line_start_reg <= at_line_start_next;
        end
    end

endmodule

// ===== rtl/elt_out_fifo.sv =====
// ----------------------------------------------------------------------------
// elt_out_fifo: result queue of the tokenizer
// Takes up to three results at once from the scanner and hands out
// one result per transfer, oldest first. DEPTH must be a power of two (not enforced).
// ----------------------------------------------------------------------------
module elt_out_fifo
    import elt_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  res_group_t results,
    output logic       room,
    output logic       empty,
    input  logic       pop,
    output out_item_t  token
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    out_item_t         mem [DEPTH];
    logic [PW-1:0]     wptr_reg;
    logic [PW-1:0]     rptr_reg;
    logic [CW-1:0]     count_reg;
    logic              pop_fire;

    assign empty    = (count_reg == '0);
    assign room     = (count_reg <= CW'(DEPTH - MAX_RESULTS));
    assign pop_fire = pop && !empty;
    assign token    = mem[rptr_reg];

    // Storage: the results of one item land in consecutive entries.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (RES_CW'(i) < results.count)
            begin
                mem[wptr_reg + PW'(i)] <= results.item[i];
            end
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_reg + PW'(results.count);
            if (pop_fire)
            begin
                rptr_reg <= rptr_reg + PW'(1);
            end
            count_reg <= count_reg + CW'(results.count) - CW'(pop_fire);
        end
    end

endmodule

// ===== rtl/expression_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// expression_line_tokenizer: streaming tokenizer for expression lines
// Cuts a stream of code points into tokens and emits one result per token
// character, tagged with kind and first, last and empty marks.
// ----------------------------------------------------------------------------
// Usage:
// Input: drive symbol and raise push; a transfer happens at a clock edge with
// push high and full low. Mark the last code point of each line with
// end_of_line; held characters of the line are released with it.
// Results: while empty is low, token shows the oldest result; it is taken at
// a clock edge with pop high. run_last marks the last result of one item.
// Path: an item's results pass through the registered input queue and the
// registered result queue before they can be taken.
// Throughput: the scanner takes one item per cycle while the result queue has
// room for three results; with pop high the result side drains one result per
// cycle, so the sustained rate is one item per cycle if items average at most one
// result. A two-entry input queue and the RESULT_DEPTH-entry result queue let
// each side stall on its own: a stalled receiver fills the result queue, then
// the input queue, then full rises.
// Reset: rst_n clears both queues and puts the scanner between tokens at the
// start of a line.
// ----------------------------------------------------------------------------
module expression_line_tokenizer
    import elt_pkg::*;
#(
    parameter int CODE_BITS    = 21,
    parameter int RESULT_DEPTH = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  symbol,
    output logic      empty,
    input  logic      pop,
    output out_item_t token
);

    logic                 head_valid;
    logic [CODE_BITS-1:0] head_code;
    char_info_t           head_info;
    logic                 head_pop;
    logic                 room;
    res_group_t           results;

    // Front: accept and classify code points.
    elt_front #(
        .CODE_BITS (CODE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .symbol     (symbol),
        .head_valid (head_valid),
        .head_code  (head_code),
        .head_info  (head_info),
        .head_pop   (head_pop)
    );

    // Back: scan state and result generation.
    elt_back #(
        .CODE_BITS (CODE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_code  (head_code),
        .head_info  (head_info),
        .head_pop   (head_pop),
        .room       (room),
        .results    (results)
    );

    // Result queue toward the receiver.
    elt_out_fifo #(
        .DEPTH (RESULT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .results (results),
        .room    (room),
        .empty   (empty),
        .pop     (pop),
        .token   (token)
    );

endmodule

// ===== rtl/elt_checker.sv =====
// ----------------------------------------------------------------------------
// elt_checker: port-level checks of the tokenizer
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
module elt_checker
    import elt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      empty,
    input logic      pop,
    input out_item_t token
);

    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result present during reset");

    // A result that is not taken stays as it is.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(token)))
        else $error("waiting result changed");

    // An empty token is a one-result string token.
    a_empty_token: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && token.token_empty) |->
        (token.token_first && token.token_last && (token.token_kind == KIND_STRING)))
        else $error("malformed empty token");

    // All results of one item are queued together.
    a_run_whole: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !token.run_last) |=> !empty)
        else $error("rest of an item's results missing");

    // After a character that does not end its token, the next one continues it.
    a_continue: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !token.token_last) |=> (empty || !token.token_first))
        else $error("token opened before the previous one closed");

endmodule

bind expression_line_tokenizer elt_checker u_elt_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .empty (empty),
    .pop   (pop),
    .token (token)
);
